FILE: hdl/zscd_pkg.sv
// Shared types, constants and cipher functions for the zip stream decryptor.
package zscd_pkg;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic       end_of_block;
	} in_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       printable;
		logic       end_of_text;
	} out_t;

	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_ABSORB  = 2'd1;
	localparam logic [1:0] OP_DECRYPT = 2'd2;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] KEY0_INIT = 32'h12345678;
	localparam logic [31:0] KEY1_INIT = 32'h23456789;
	localparam logic [31:0] KEY2_INIT = 32'h34567890;
	localparam logic [31:0] LCG_MULT  = 32'd134775813;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_LOW   = 8'd48;
	localparam logic [7:0] CHAR_HIGH  = 8'd122;

	typedef enum logic [1:0] {
		S_IDLE,
		S_KEY1,
		S_KEY2,
		S_KS
	} state_t;

	typedef struct packed {
		logic load_init;
		logic k0_step;
		logic use_plain;
		logic out_load;
		logic k1_step;
		logic k2_step;
		logic ks_step;
	} cmd_t;

	typedef logic [31:0] crc_rom_t [256];

	function automatic crc_rom_t crc_rom_build();
		crc_rom_t   rom;
		logic [31:0] v;
		for (int i = 0; i < 256; i++) begin
			v = 32'(i);
			for (int j = 0; j < 8; j++) begin
				v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
			end
			rom[i] = v;
		end
		return rom;
	endfunction

	localparam crc_rom_t CRC_TABLE = crc_rom_build();

	// One CRC-32 byte step through the constant table.
	function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
		logic [7:0] idx;
		idx = crc[7:0] ^ b;
		return CRC_TABLE[idx] ^ (crc >> 8);
	endfunction

	// Keystream byte from the low half of key two.
	function automatic logic [7:0] ks_byte(logic [31:0] k2);
		logic [15:0] t;
		logic [31:0] prod;
		t    = {k2[15:2], 1'b1, k2[0]};
		prod = {16'd0, t} * {16'd0, t ^ 16'd1};
		return prod[15:8];
	endfunction

	localparam logic [7:0] KS_INIT = ks_byte(KEY2_INIT);

endpackage

FILE: hdl/zip_stream_cipher_decrypt.sv
// Top level of the zip stream decryptor: controller plus key datapath.
//
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+----------------------------------------
// in      | input     | in_valid / in_ready   | in_data  (op, data_byte, end_of_block)
// out     | output    | out_valid / out_ready | out_data (plain_byte, printable, end_of_text)
//
// An absorb or decrypt item is sequenced: the transfer cycle updates key zero,
// then key one (add and 32-bit multiply), key two (CRC step) and the keystream
// byte follow, one state each. Restart reloads the keys, then the byte; op 3 does nothing.
// A decrypt result is registered at the transfer and held until taken; a new transfer
// waits while a sequence runs or while an untaken result is held without out_ready.
// Reset loads the three initial keys and their keystream byte at once.
module zip_stream_cipher_decrypt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  zscd_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output zscd_pkg::out_t  out_data
);

	// Command bundle from the sequencer to the key datapath.
	zscd_pkg::cmd_t cmd;

	// Sequence each transfer through the key updates; own the output valid.
	zscd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_op     (in_data.op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Hold the keys and the keystream byte; decrypt and register the result.
	zscd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_data (out_data)
	);

endmodule

FILE: hdl/zscd_ctrl.sv
// Controller state machine for the zip stream decryptor.
module zscd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_op,
	output logic            out_valid,
	input  logic            out_ready,
	output zscd_pkg::cmd_t  cmd
);

	zscd_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             accept;

	assign in_ready  = (state_q == zscd_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			zscd_pkg::S_IDLE: begin
				if (accept) begin
					case (in_op)
						zscd_pkg::OP_RESTART: state_d = zscd_pkg::S_KS;
						zscd_pkg::OP_ABSORB:  state_d = zscd_pkg::S_KEY1;
						zscd_pkg::OP_DECRYPT: state_d = zscd_pkg::S_KEY1;
						default:              state_d = zscd_pkg::S_IDLE;
					endcase
				end
			end
			zscd_pkg::S_KEY1: state_d = zscd_pkg::S_KEY2;
			zscd_pkg::S_KEY2: state_d = zscd_pkg::S_KS;
			zscd_pkg::S_KS:   state_d = zscd_pkg::S_IDLE;
			default:          state_d = zscd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load_init = accept && (in_op == zscd_pkg::OP_RESTART);
		cmd.k0_step   = accept && ((in_op == zscd_pkg::OP_ABSORB) ||
		                           (in_op == zscd_pkg::OP_DECRYPT));
		cmd.use_plain = (in_op == zscd_pkg::OP_DECRYPT);
		cmd.out_load  = accept && (in_op == zscd_pkg::OP_DECRYPT);
		cmd.k1_step   = (state_q == zscd_pkg::S_KEY1);
		cmd.k2_step   = (state_q == zscd_pkg::S_KEY2);
		cmd.ks_step   = (state_q == zscd_pkg::S_KS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zscd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/zscd_dp.sv
// Key registers, keystream register and result register of the zip stream decryptor.
module zscd_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  zscd_pkg::in_t  in_data,
	input  zscd_pkg::cmd_t cmd,
	output zscd_pkg::out_t out_data
);

	logic [31:0] key0_q, key1_q, key2_q;
	logic [7:0]  ks_q;
	logic [7:0]  plain;
	logic [7:0]  mix_byte;
	logic [31:0] k1_sum;
	logic [31:0] k1_prod;
	zscd_pkg::out_t out_q;

	assign plain    = in_data.data_byte ^ ks_q;
	assign mix_byte = cmd.use_plain ? plain : in_data.data_byte;
	assign k1_sum   = key1_q + {24'd0, key0_q[7:0]};
	assign k1_prod  = k1_sum * zscd_pkg::LCG_MULT;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= zscd_pkg::KEY0_INIT;
			key1_q <= zscd_pkg::KEY1_INIT;
			key2_q <= zscd_pkg::KEY2_INIT;
			ks_q   <= zscd_pkg::KS_INIT;
		end else begin
			if (cmd.load_init) begin
				key0_q <= zscd_pkg::KEY0_INIT;
				key1_q <= zscd_pkg::KEY1_INIT;
				key2_q <= zscd_pkg::KEY2_INIT;
			end else begin
				if (cmd.k0_step) key0_q <= zscd_pkg::crc_step(key0_q, mix_byte);
				if (cmd.k1_step) key1_q <= k1_prod + 32'd1;
				if (cmd.k2_step) key2_q <= zscd_pkg::crc_step(key2_q, key1_q[31:24]);
			end
			if (cmd.ks_step) ks_q <= zscd_pkg::ks_byte(key2_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.plain_byte  <= plain;
			out_q.printable   <= plain inside {zscd_pkg::CHAR_SPACE,
			                                   [zscd_pkg::CHAR_LOW:zscd_pkg::CHAR_HIGH]};
			out_q.end_of_text <= in_data.end_of_block;
		end
	end

endmodule
